// ===== sv/mi3_pkg.sv =====
// ----------------------------------------------------------------------------
// mi3_pkg: shared types and constants for the 3x3 matrix inverse
// Element format, derived widths, pipeline stage numbers and the shared
// sign-and-saturate helper.
// ----------------------------------------------------------------------------
package mi3_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int N_ELEM     = 9;

  // Cofactor: difference of two full products
  localparam int COF_W     = 2 * DATA_WIDTH + 1;
  // Determinant: sum of three element-by-cofactor products
  localparam int DET_W     = 3 * DATA_WIDTH + 3;
  localparam int DMAG_W    = DET_W;
  // Quotient bits of floor(2N/D); anything larger saturates
  localparam int Q_BITS    = DATA_WIDTH + 2;
  localparam int NUM_W     = COF_W + 2 * FRAC_BITS + 1;
  localparam int REM_W     = DMAG_W + Q_BITS;
  localparam int SAT_W     = DMAG_W + 1;
  localparam int DET_SHIFT = 2 * FRAC_BITS;

  // Stage numbers: magnitudes, then precheck, then one stage per quotient bit
  localparam int STG_MAG = 5;
  localparam int STG_END = STG_MAG + 1 + Q_BITS;

  typedef logic signed [DATA_WIDTH-1:0] elem_t;
  typedef logic signed [COF_W-1:0]      cof_t;
  typedef logic signed [DET_W-1:0]      det_t;
  typedef logic        [DMAG_W-1:0]     dmag_t;
  typedef dmag_t       [Q_BITS:0]       dmag_pipe_t;

  localparam elem_t ELEM_MAX = elem_t'({1'b0, {(DATA_WIDTH-1){1'b1}}});
  localparam elem_t ELEM_MIN = elem_t'({1'b1, {(DATA_WIDTH-1){1'b0}}});
  localparam logic [SAT_W-1:0] DET_HALF = (SAT_W'(1) << DET_SHIFT) >> 1;

  typedef struct packed {
    elem_t val;
    logic  ovf;
  } sat_t;

  typedef struct packed {
    logic  dneg;
    logic  dzero;
    elem_t det_val;
    logic  det_ovf;
  } side_t;

  typedef struct packed {
    elem_t [N_ELEM-1:0] inv;
    elem_t              det_value;
    logic               singular;
    logic               overflow;
  } res_t;

  // Apply sign to a rounded magnitude and clamp to the element range
  function automatic sat_t sat_mag(input logic [SAT_W-1:0] mag, input logic neg,
                                   input logic force_ovf);
    sat_t             s;
    logic [SAT_W-1:0] lim;
    lim   = SAT_W'(1) << (DATA_WIDTH - 1);
    s.ovf = force_ovf || (neg ? (mag > lim) : (mag >= lim));
    if (s.ovf) begin
      s.val = neg ? ELEM_MIN : ELEM_MAX;
    end else if (neg) begin
      s.val = elem_t'(-mag[DATA_WIDTH-1:0]);
    end else begin
      s.val = elem_t'(mag[DATA_WIDTH-1:0]);
    end
    return s;
  endfunction

endpackage

// ===== sv/mi3_if.sv =====
// ----------------------------------------------------------------------------
// mi3_if: valid/ready channels of the 3x3 matrix inverse
// Input channel carries one matrix, output channel one result.
// ----------------------------------------------------------------------------
interface mi3_in_if;
  logic           valid;
  logic           ready;
  mi3_pkg::elem_t m00, m01, m02, m10, m11, m12, m20, m21, m22;

  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  input ready);
  modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  output ready);
endinterface

interface mi3_out_if;
  logic           valid;
  logic           ready;
  mi3_pkg::elem_t inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22;
  mi3_pkg::elem_t det_value;
  logic           singular;
  logic           overflow;

  modport source (output valid, inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21,
                  inv22, det_value, singular, overflow, input ready);
  modport sink   (input valid, inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21,
                  inv22, det_value, singular, overflow, output ready);
endinterface

// ===== sv/mi3_cof_lane.sv =====
// ----------------------------------------------------------------------------
// mi3_cof_lane: one cofactor lane
// Two products, then their signed difference with the checkerboard sign.
// ----------------------------------------------------------------------------
module mi3_cof_lane (
  input  logic           clk,
  input  logic           en,
  input  mi3_pkg::elem_t a,
  input  mi3_pkg::elem_t b,
  input  mi3_pkg::elem_t c,
  input  mi3_pkg::elem_t d,
  input  logic           flip,
  output mi3_pkg::cof_t  cof
);

  logic signed [2*mi3_pkg::DATA_WIDTH-1:0] p_r, q_r;
  logic                                    flip_r;
  mi3_pkg::cof_t                           cof_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r    <= a * b;
      q_r    <= c * d;
      flip_r <= flip;
      cof_r  <= flip_r ? (mi3_pkg::COF_W'(q_r) - mi3_pkg::COF_W'(p_r))
                       : (mi3_pkg::COF_W'(p_r) - mi3_pkg::COF_W'(q_r));
    end
  end

  assign cof = cof_r;

endmodule

// ===== sv/mi3_det_merge.sv =====
// ----------------------------------------------------------------------------
// mi3_det_merge: determinant merge
// First-row expansion; each wide product is split into two partial products.
// ----------------------------------------------------------------------------
module mi3_det_merge (
  input  logic           clk,
  input  logic           en,
  input  mi3_pkg::elem_t row [3],
  input  mi3_pkg::cof_t  cof [3],
  output mi3_pkg::det_t  det
);

  localparam int DW = mi3_pkg::DATA_WIDTH;

  logic signed [2*DW:0] pl_r [3];
  logic signed [2*DW:0] ph_r [3];
  mi3_pkg::det_t        det_r, det_nxt;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pl_r[i] <= row[i] * $signed({1'b0, cof[i][DW-1:0]});
        ph_r[i] <= row[i] * $signed(cof[i][mi3_pkg::COF_W-1:DW]);
      end
      det_r <= det_nxt;
    end
  end

  // Recombine partials and sum the three terms
  always_comb begin
    det_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      det_nxt = det_nxt + (mi3_pkg::DET_W'(ph_r[i]) <<< DW) + mi3_pkg::DET_W'(pl_r[i]);
    end
  end

  assign det = det_r;

endmodule

// ===== sv/mi3_div_lane.sv =====
// ----------------------------------------------------------------------------
// mi3_div_lane: one inverse element
// Pipelined restoring division of the scaled cofactor by the determinant,
// one quotient bit per stage, then round and saturate.
// ----------------------------------------------------------------------------
module mi3_div_lane (
  input  logic                clk,
  input  logic                en,
  input  mi3_pkg::cof_t       cof,
  input  mi3_pkg::dmag_pipe_t dmag_pipe,
  input  logic                dneg,
  output mi3_pkg::sat_t       res
);

  localparam int QB = mi3_pkg::Q_BITS;
  localparam int RW = mi3_pkg::REM_W;

  logic [mi3_pkg::COF_W-1:0] cmag;
  logic [mi3_pkg::NUM_W-1:0] num_r;
  logic                      cneg5_r;
  logic [RW-1:0]             rem_r  [QB+1];
  logic [QB-1:0]             quo_r  [QB+1];
  logic                      pre_r  [QB+1];
  logic                      cneg_r [QB+1];
  logic [mi3_pkg::SAT_W-1:0] rnd;

  assign cmag = cof[mi3_pkg::COF_W-1] ? mi3_pkg::COF_W'(-cof) : mi3_pkg::COF_W'(cof);

  // Magnitude, precheck against the largest representable quotient
  always_ff @(posedge clk) begin
    if (en) begin
      num_r     <= mi3_pkg::NUM_W'(cmag) << (2 * mi3_pkg::FRAC_BITS + 1);
      cneg5_r   <= cof[mi3_pkg::COF_W-1];
      rem_r[0]  <= RW'(num_r);
      quo_r[0]  <= '0;
      pre_r[0]  <= RW'(num_r) >= (RW'(dmag_pipe[0]) << QB);
      cneg_r[0] <= cneg5_r;
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_step
    localparam int K = QB - 1 - j;
    logic [RW-1:0] sub;
    logic          ge;
    assign sub = RW'(dmag_pipe[j+1]) << K;
    assign ge  = rem_r[j] >= sub;
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j+1]  <= ge ? (rem_r[j] - sub) : rem_r[j];
        quo_r[j+1]  <= quo_r[j] | (QB'(ge) << K);
        pre_r[j+1]  <= pre_r[j];
        cneg_r[j+1] <= cneg_r[j];
      end
    end
  end

  // floor(2N/D) plus one, halved: nearest with ties away from zero
  assign rnd = (mi3_pkg::SAT_W'(quo_r[QB]) + mi3_pkg::SAT_W'(1)) >> 1;
  assign res = mi3_pkg::sat_mag(rnd, cneg_r[QB] ^ dneg, pre_r[QB]);

endmodule

// ===== sv/matrix_inverse_3x3.sv =====
// ----------------------------------------------------------------------------
// matrix_inverse_3x3: adjugate inverse of a 3x3 signed Q16.16 matrix
// Nine cofactor lanes, a determinant merge, nine division lanes and a
// two-entry output buffer.
// ----------------------------------------------------------------------------
//
//   channel  | port    | per transfer
//   ---------+---------+-----------------------------------------------------
//   input    | in_ch   | m00..m22, one matrix
//   output   | out_ch  | inv00..inv22, det_value, singular, overflow
//
// One matrix per cycle while the output skid slot is empty. The division
// lanes take one quotient bit (34 bits) per stage, behind five stages of
// capture, products, cofactors and the determinant, one magnitude stage
// and one range-check stage.
// rst_n clears only the valid bits. Every stage advances together while the
// output skid slot is empty; a stalled output keeps taking input until a
// result reaches the end of the pipe and lands in that slot, and in_ch.ready
// drops the cycle after.
//
module matrix_inverse_3x3 (
  input  logic         clk,
  input  logic         rst_n,
  mi3_in_if.sink       in_ch,
  mi3_out_if.source    out_ch
);

  localparam int N  = mi3_pkg::N_ELEM;
  localparam int SM = mi3_pkg::STG_MAG;
  localparam int SE = mi3_pkg::STG_END;

  logic                  en;
  logic [SE:0]           v_r;
  mi3_pkg::elem_t        m_r    [N];
  mi3_pkg::elem_t        row1_r [3];
  mi3_pkg::elem_t        row2_r [3];
  mi3_pkg::cof_t         cof2   [N];
  mi3_pkg::cof_t         cof3_r [N];
  mi3_pkg::cof_t         cof4_r [N];
  mi3_pkg::det_t         det4;
  mi3_pkg::dmag_t        dmag_r [SM:SE-1];
  mi3_pkg::side_t        side_r [SM:SE];
  mi3_pkg::dmag_pipe_t   dmag_pipe;
  mi3_pkg::sat_t         lane_res [N];
  mi3_pkg::sat_t         det_sat;
  logic [mi3_pkg::SAT_W-1:0] det_rnd;
  mi3_pkg::res_t         res;
  mi3_pkg::res_t         out_r, skd_r;
  logic                  out_v_r, skd_v_r;
  logic                  push;

  // Hold the whole pipe only while the skid slot is occupied
  assign en          = !skd_v_r;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[SE-1:0], in_ch.valid};
    end
  end

  // Stage 0: capture the matrix; also delay row 0 and the cofactors
  always_ff @(posedge clk) begin
    if (en) begin
      m_r[0] <= in_ch.m00; m_r[1] <= in_ch.m01; m_r[2] <= in_ch.m02;
      m_r[3] <= in_ch.m10; m_r[4] <= in_ch.m11; m_r[5] <= in_ch.m12;
      m_r[6] <= in_ch.m20; m_r[7] <= in_ch.m21; m_r[8] <= in_ch.m22;
      for (int i = 0; i < 3; i++) begin
        row1_r[i] <= m_r[i];
        row2_r[i] <= row1_r[i];
      end
      cof3_r <= cof2;
      cof4_r <= cof3_r;
    end
  end

  // Stages 1-2: cofactor lanes, each the 2x2 minor left by deleting row r, col c
  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      localparam int RA = (r == 0) ? 1 : 0;
      localparam int RB = (r == 2) ? 1 : 2;
      localparam int CA = (c == 0) ? 1 : 0;
      localparam int CB = (c == 2) ? 1 : 2;
      mi3_cof_lane u_cof (
        .clk  (clk),
        .en   (en),
        .a    (m_r[RA*3+CA]),
        .b    (m_r[RB*3+CB]),
        .c    (m_r[RA*3+CB]),
        .d    (m_r[RB*3+CA]),
        .flip (((r + c) % 2) == 1),
        .cof  (cof2[r*3+c])
      );
    end
  end

  // Stages 3-4: merge row 0 with its cofactors
  mi3_det_merge u_det (
    .clk (clk),
    .en  (en),
    .row (row2_r),
    .cof (cof2[0:2]),
    .det (det4)
  );

  // Stage 5: determinant sign and magnitude; stage 6: rounded det_value
  assign det_rnd = (mi3_pkg::SAT_W'(dmag_r[SM]) + mi3_pkg::DET_HALF) >> mi3_pkg::DET_SHIFT;
  assign det_sat = mi3_pkg::sat_mag(det_rnd, side_r[SM].dneg, 1'b0);

  always_ff @(posedge clk) begin
    if (en) begin
      dmag_r[SM] <= det4[mi3_pkg::DET_W-1] ? mi3_pkg::DMAG_W'(-det4)
                                           : mi3_pkg::DMAG_W'(det4);
      side_r[SM] <= '{dneg: det4[mi3_pkg::DET_W-1], dzero: (det4 == '0),
                      det_val: '0, det_ovf: 1'b0};
      side_r[SM+1] <= '{dneg: side_r[SM].dneg, dzero: side_r[SM].dzero,
                        det_val: det_sat.val, det_ovf: det_sat.ovf};
      for (int s = SM + 1; s < SE; s++) begin
        dmag_r[s] <= dmag_r[s-1];
      end
      for (int s = SM + 2; s <= SE; s++) begin
        side_r[s] <= side_r[s-1];
      end
    end
  end

  // Divisor copy seen by each division stage
  always_comb begin
    for (int j = 0; j <= mi3_pkg::Q_BITS; j++) begin
      dmag_pipe[j] = dmag_r[SM+j];
    end
  end

  // Stages 5-40: division lanes on the transposed cofactors
  for (genvar i = 0; i < N; i++) begin : g_div
    mi3_div_lane u_div (
      .clk       (clk),
      .en        (en),
      .cof       (cof4_r[(i % 3) * 3 + (i / 3)]),
      .dmag_pipe (dmag_pipe),
      .dneg      (side_r[SE].dneg),
      .res       (lane_res[i])
    );
  end

  // Drop everything but the flag on a singular matrix
  always_comb begin
    res.overflow = side_r[SE].det_ovf;
    for (int i = 0; i < N; i++) begin
      res.inv[i]   = side_r[SE].dzero ? '0 : lane_res[i].val;
      res.overflow = res.overflow | lane_res[i].ovf;
    end
    res.overflow  = res.overflow & !side_r[SE].dzero;
    res.det_value = side_r[SE].dzero ? '0 : side_r[SE].det_val;
    res.singular  = side_r[SE].dzero;
  end

  // Output register plus one skid slot
  assign push = en && v_r[SE];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      skd_v_r <= 1'b0;
    end else if (!out_v_r || out_ch.ready) begin
      out_v_r <= skd_v_r || push;
      skd_v_r <= 1'b0;
    end else if (push) begin
      skd_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_ch.ready) begin
      out_r <= skd_v_r ? skd_r : res;
    end else if (push) begin
      skd_r <= res;
    end
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.inv00     = out_r.inv[0];
  assign out_ch.inv01     = out_r.inv[1];
  assign out_ch.inv02     = out_r.inv[2];
  assign out_ch.inv10     = out_r.inv[3];
  assign out_ch.inv11     = out_r.inv[4];
  assign out_ch.inv12     = out_r.inv[5];
  assign out_ch.inv20     = out_r.inv[6];
  assign out_ch.inv21     = out_r.inv[7];
  assign out_ch.inv22     = out_r.inv[8];
  assign out_ch.det_value = out_r.det_value;
  assign out_ch.singular  = out_r.singular;
  assign out_ch.overflow  = out_r.overflow;

endmodule

// ===== test/matrix_inverse_3x3_checker.sv =====
// ----------------------------------------------------------------------------
// matrix_inverse_3x3_checker: result predictor and scoreboard
// Watches both channels, works out the exact adjugate inverse of every
// accepted matrix and compares each accepted result with the oldest one due.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3_checker (
  input  logic  clk,
  input  logic  rst_n,
  mi3_in_if     in_mon,
  mi3_out_if    out_mon,
  output int    mismatches,
  output int    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [127:0] wide_t;
  typedef logic        [127:0] umag_t;

  typedef struct packed {
    mi3_pkg::elem_t [8:0] inv;
    mi3_pkg::elem_t       det;
    logic                 singular;
    logic                 overflow;
  } inverse_t;

  inverse_t due_inverses[$];
  int       err_count = 0;
  int       due_count = 0;

  assign mismatches = err_count;
  assign pending    = due_count;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch %s: got %h want %h", $realtime, what, got, want);
    err_count++;
  endtask

  // Round num/den to nearest, ties away from zero, and clamp to the element range.
  function automatic mi3_pkg::elem_t div_round_sat(input wide_t num, input wide_t den,
                                                   inout logic ovf);
    logic  neg;
    umag_t n, d, q, r, lim;
    neg = num[127] ^ den[127];
    n   = num[127] ? umag_t'(-num) : umag_t'(num);
    d   = den[127] ? umag_t'(-den) : umag_t'(den);
    q   = n / d;
    r   = n % d;
    if ((r << 1) >= d) q = q + 1;
    lim = umag_t'(1) << (mi3_pkg::DATA_WIDTH - 1);
    if (!neg) begin
      if (q > lim - 1) begin
        ovf = 1'b1;
        return mi3_pkg::ELEM_MAX;
      end
      return mi3_pkg::elem_t'(q[mi3_pkg::DATA_WIDTH-1:0]);
    end
    if (q > lim) begin
      ovf = 1'b1;
      return mi3_pkg::ELEM_MIN;
    end
    return mi3_pkg::elem_t'(-q[mi3_pkg::DATA_WIDTH-1:0]);
  endfunction

  function automatic inverse_t compute_inverse(input mi3_pkg::elem_t m [9]);
    wide_t    cof [3][3];
    wide_t    det;
    int       ra, rb, ca, cb;
    logic     ovf;
    inverse_t res;
    res = '0;
    ovf = 1'b0;
    for (int r = 0; r < 3; r++) begin
      ra = (r == 0) ? 1 : 0;
      rb = (r == 2) ? 1 : 2;
      for (int c = 0; c < 3; c++) begin
        ca = (c == 0) ? 1 : 0;
        cb = (c == 2) ? 1 : 2;
        cof[r][c] = wide_t'(m[ra*3+ca]) * wide_t'(m[rb*3+cb])
                  - wide_t'(m[ra*3+cb]) * wide_t'(m[rb*3+ca]);
        if ((r + c) % 2 == 1) cof[r][c] = -cof[r][c];
      end
    end
    det = '0;
    for (int c = 0; c < 3; c++) det = det + wide_t'(m[c]) * cof[0][c];
    if (det == 0) begin
      res.singular = 1'b1;
      return res;
    end
    // Transpose the cofactors while scaling by the reciprocal of the determinant
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        res.inv[r*3+c] = div_round_sat(cof[c][r] <<< (2 * mi3_pkg::FRAC_BITS), det, ovf);
    res.det      = div_round_sat(det, wide_t'(1) <<< (2 * mi3_pkg::FRAC_BITS), ovf);
    res.overflow = ovf;
    return res;
  endfunction

  always @(posedge clk) begin
    mi3_pkg::elem_t m [9];
    inverse_t       got, want;
    if (rst_n && in_mon.valid && in_mon.ready) begin
      m = '{in_mon.m00, in_mon.m01, in_mon.m02, in_mon.m10, in_mon.m11, in_mon.m12,
            in_mon.m20, in_mon.m21, in_mon.m22};
      due_inverses.push_back(compute_inverse(m));
    end
    if (rst_n && out_mon.valid && out_mon.ready) begin
      got.inv      = {out_mon.inv22, out_mon.inv21, out_mon.inv20, out_mon.inv12,
                      out_mon.inv11, out_mon.inv10, out_mon.inv02, out_mon.inv01,
                      out_mon.inv00};
      got.det      = out_mon.det_value;
      got.singular = out_mon.singular;
      got.overflow = out_mon.overflow;
      if (due_inverses.size() == 0) begin
        report_mismatch("result with none due", got.det, '0);
      end else begin
        want = due_inverses.pop_front();
        for (int i = 0; i < 9; i++)
          if (got.inv[i] !== want.inv[i])
            report_mismatch($sformatf("inv%0d%0d", i / 3, i % 3), got.inv[i], want.inv[i]);
        if (got.det !== want.det) report_mismatch("det_value", got.det, want.det);
        if (got.singular !== want.singular)
          report_mismatch("singular", 32'(got.singular), 32'(want.singular));
        if (got.overflow !== want.overflow)
          report_mismatch("overflow", 32'(got.overflow), 32'(want.overflow));
      end
    end
    due_count = due_inverses.size();
  end

endmodule

// ===== test/matrix_inverse_3x3_test.sv =====
// ----------------------------------------------------------------------------
// matrix_inverse_3x3_test: stimulus and verdict for the 3x3 matrix inverse
// Sends directed matrices (identity, singular, extremes, tiny determinant,
// rounding ties) and then random matrices in bursts against a stalling
// receiver; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int             N_RANDOM    = 1080;
  localparam int             CYCLE_LIMIT = 400000;
  localparam int             DRAIN_WAIT  = 60;
  localparam mi3_pkg::elem_t ONE         = mi3_pkg::elem_t'(32'h0001_0000);
  localparam mi3_pkg::elem_t EMAX        = mi3_pkg::ELEM_MAX;
  localparam mi3_pkg::elem_t EMIN        = mi3_pkg::ELEM_MIN;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   mismatches, pending;
  int   cycle_count = 0;
  bit   holdoff_req = 1'b0;

  mi3_in_if  in_ch ();
  mi3_out_if out_ch ();

  matrix_inverse_3x3 i_dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  matrix_inverse_3x3_checker i_checker (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
    .mismatches(mismatches), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a stuck handshake must not hang the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver: random 16-bit stall pattern, refreshed once used up, sometimes no stall
  // at all; a hold-off request drops ready for a long stretch so the pipe fills.
  initial begin
    logic [15:0] pattern;
    out_ch.ready = 1'b0;
    forever begin
      case ($urandom_range(0, 3))
        0:       pattern = '1;
        1:       pattern = 16'($urandom) | 16'($urandom);
        default: pattern = 16'($urandom);
      endcase
      for (int i = 0; i < 16; i++) begin
        @(posedge clk);
        if (holdoff_req) begin
          out_ch.ready <= 1'b0;
          for (int k = 0; k < 200; k++) @(posedge clk);
          holdoff_req = 1'b0;
        end
        out_ch.ready <= pattern[i];
      end
    end
  end

  // Drive one matrix and hold it until the block takes it; valid stays high
  // so back-to-back transfers keep flowing within a burst.
  task automatic send_matrix(input mi3_pkg::elem_t m [9]);
    in_ch.valid <= 1'b1;
    {in_ch.m00, in_ch.m01, in_ch.m02, in_ch.m10, in_ch.m11, in_ch.m12,
     in_ch.m20, in_ch.m21, in_ch.m22} <= {m[0], m[1], m[2], m[3], m[4], m[5], m[6], m[7],
                                          m[8]};
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drop valid only for a real gap; a zero gap keeps the burst going
  task automatic idle_gap(input int cycles);
    if (cycles > 0) in_ch.valid <= 1'b0;
    for (int i = 0; i < cycles; i++) @(posedge clk);
  endtask

  // Mostly modest values near unity so the inverse stays in range, plus some
  // full-range noise that exercises every bit and the saturation path.
  function automatic mi3_pkg::elem_t pick_element(input int mode);
    case (mode)
      0:       return mi3_pkg::elem_t'($urandom);
      1:       return mi3_pkg::elem_t'($signed($urandom_range(0, 32'h0008_0000))
                                       - 32'sh0004_0000);
      2:       return mi3_pkg::elem_t'($signed($urandom_range(0, 255)) - 128);
      default: return mi3_pkg::elem_t'($signed($urandom_range(0, 32'h0100_0000))
                                       - 32'sh0080_0000);
    endcase
  endfunction

  initial begin
    mi3_pkg::elem_t m [9];
    mi3_pkg::elem_t directed [$][9];
    int             mode, burst;
    bit             paused;

    paused = 1'b0;
    in_ch.valid = 1'b0;
    {in_ch.m00, in_ch.m01, in_ch.m02, in_ch.m10, in_ch.m11, in_ch.m12,
     in_ch.m20, in_ch.m21, in_ch.m22} = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Identity, negated identity, zero matrix, uniform extremes
    directed.push_back('{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE});
    directed.push_back('{-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE});
    directed.push_back('{0, 0, 0, 0, 0, 0, 0, 0, 0});
    directed.push_back('{default: EMAX});
    directed.push_back('{default: EMIN});
    // Extreme diagonals: huge determinant and saturated det
    directed.push_back('{EMAX, 0, 0, 0, EMAX, 0, 0, 0, EMAX});
    directed.push_back('{EMIN, 0, 0, 0, EMIN, 0, 0, 0, EMIN});
    directed.push_back('{EMIN, EMAX, 0, EMAX, EMIN, EMAX, 0, EMAX, EMIN});
    // Tiny determinant: nonzero but rounds to zero; inverse saturates
    directed.push_back('{1, 0, 0, 0, 1, 0, 0, 0, 1});
    directed.push_back('{-1, 0, 0, 0, 1, 0, 0, 0, 1});
    // Determinant exactly half an LSB: ties away from zero in both signs
    directed.push_back('{1, 0, 0, 0, 32'sh8000, 0, 0, 0, ONE});
    directed.push_back('{-1, 0, 0, 0, 32'sh8000, 0, 0, 0, ONE});
    // Singular: repeated rows, a zero column, a rank-one matrix
    directed.push_back('{ONE, 2*ONE, 3*ONE, ONE, 2*ONE, 3*ONE, 4*ONE, 5*ONE, 6*ONE});
    directed.push_back('{0, ONE, 2*ONE, 0, 3*ONE, ONE, 0, -ONE, 5*ONE});
    directed.push_back('{ONE, 2*ONE, 3*ONE, 2*ONE, 4*ONE, 6*ONE, 3*ONE, 6*ONE, 9*ONE});
    // Regular matrices with off-diagonal structure and exact halves
    directed.push_back('{2*ONE, 0, 0, 0, 2*ONE, 0, 0, 0, 2*ONE});
    directed.push_back('{0, ONE, 0, 0, 0, ONE, ONE, 0, 0});
    directed.push_back('{2*ONE, ONE, 0, ONE, 3*ONE, ONE, 0, ONE, 4*ONE});
    directed.push_back('{4*ONE, 7*ONE, 2*ONE, 3*ONE, 6*ONE, ONE, 2*ONE, 5*ONE, 3*ONE});
    directed.push_back('{32'sh0000_8000, 0, 0, 0, -32'sh0000_4000, 0, 0, 0, 32'sh7FFF_0000});
    foreach (directed[i]) send_matrix(directed[i]);
    idle_gap(1);

    // Let every directed result drain before the random part
    while (pending != 0) @(posedge clk);

    for (int n = 0; n < N_RANDOM; ) begin
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      for (int b = 0; b < burst && n < N_RANDOM; b++, n++) begin
        mode = $urandom_range(0, 9);
        foreach (m[k]) m[k] = pick_element(mode < 2 ? 0 : (mode < 6 ? 1 : (mode < 8 ? 3 : 2)));
        // Occasionally force a singular matrix by copying one row onto another
        if ($urandom_range(0, 19) == 0) begin
          m[3] = m[0];
          m[4] = m[1];
          m[5] = m[2];
        end
        send_matrix(m);
        if (n == 300) holdoff_req = 1'b1;
      end
      if (n >= 700 && !paused) begin
        // Pause the sender until every outstanding result has come back
        paused = 1'b1;
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      idle_gap($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6));
    end
    in_ch.valid <= 1'b0;
    @(posedge clk);

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
